@@ hw/rtl/batched_weight_optimizer_top_assert.svh @@
`ifndef BATCHED_WEIGHT_OPTIMIZER_TOP_ASSERT_SVH
`define BATCHED_WEIGHT_OPTIMIZER_TOP_ASSERT_SVH

// same-cycle implication
`define BWO_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bwo assertion failed");

// next-cycle implication
`define BWO_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bwo assertion failed");

`endif

@@ hw/rtl/bwo_pkg.sv @@
package bwo_pkg;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} unit_op_t;

	typedef struct packed {
		unit_op_t    op;
		logic [95:0] a;
		logic [63:0] b;
		logic [6:0]  len;
	} unit_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] res;
	} unit_rsp_t;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_BATCH,
		REG_LRATE,
		REG_FRATE,
		REG_WMIN,
		REG_WMAX,
		REG_DECAY1,
		REG_DECAY2
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_IDX,
		ST_CHK,
		ST_MEAN,
		ST_GD,
		ST_P1,
		ST_P2,
		ST_SQ1,
		ST_X,
		ST_ALPHA,
		ST_M1A,
		ST_M1B,
		ST_GSQ,
		ST_M2A,
		ST_M2B,
		ST_SQ2,
		ST_T,
		ST_DSTEP,
		ST_QINIT,
		ST_QTEST,
		ST_QMR,
		ST_QMB,
		ST_QPOW,
		ST_QMOM,
		ST_CLAMP,
		ST_DONE
	} state_t;

	localparam logic [32:0]  ONE32      = 33'h1_0000_0000;
	localparam logic [63:0]  EPSILON    = 64'd429;
	localparam logic [32:0]  CATCH_UP   = 33'd16;
	localparam logic [95:0]  DELTA_CAP  = 96'h2_0000_0000_0000;
	localparam logic [95:0]  T_CAP      = 96'h4000_0000_0000_0000;
	localparam logic [95:0]  GSQ_CAP    = 96'h7FFF_FFFF_FFFF;
	localparam logic [47:0]  S48MAX     = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0]  S48MIN     = 48'h8000_0000_0000;

	localparam logic [31:0]  RST_RATE   = 32'd429497;
	localparam logic [47:0]  RST_WMIN   = 48'hFF9C_0000_0000;
	localparam logic [47:0]  RST_WMAX   = 48'h0064_0000_0000;
	localparam logic [31:0]  RST_DECAY1 = 32'hE666_6666;
	localparam logic [31:0]  RST_DECAY2 = 32'hFFBE_76C9;

	function automatic logic [47:0] mag48(logic [47:0] x);
		return x[47] ? (48'd0 - x) : x;
	endfunction

	function automatic logic signed [47:0] sat48(logic signed [63:0] x);
		logic signed [47:0] r;
		if (x > 64'sh0000_7FFF_FFFF_FFFF)
			r = S48MAX;
		else if (x < 64'shFFFF_8000_0000_0000)
			r = S48MIN;
		else
			r = x[47:0];
		return r;
	endfunction

	function automatic unit_req_t mk_req(unit_op_t op, logic [95:0] a, logic [63:0] b,
					     logic [6:0] len);
		unit_req_t r;
		r.op  = op;
		r.a   = a;
		r.b   = b;
		r.len = len;
		return r;
	endfunction

endpackage

@@ hw/rtl/bwo_if.sv @@
interface bwo_item_if;
	logic               valid;
	logic               ready;
	logic [31:0]        update_index;
	logic signed [47:0] gradient;
	logic signed [47:0] weight_in;

	modport source (output valid, update_index, gradient, weight_in, input ready);
	modport sink (input valid, update_index, gradient, weight_in, output ready);
endinterface

interface bwo_result_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] weight_out;
	logic               updated;

	modport source (output valid, weight_out, updated, input ready);
	modport sink (input valid, weight_out, updated, output ready);
endinterface

@@ hw/rtl/bwo_unit.sv @@
module bwo_unit
	import bwo_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	logic         busy_q;
	logic         done_q;
	unit_op_t     op_q;
	logic [6:0]   cnt_q;
	logic [95:0]  a_q;
	logic [63:0]  b_q;
	logic [127:0] acc_q;
	logic [64:0]  rem_q;

	logic [1:0]   pp_sel;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [64:0]  dtry;
	logic         dge;
	logic [51:0]  stry;
	logic [51:0]  strial;
	logic         sge;

	always_comb begin
		pp_sel = ~cnt_q[1:0];
		pp     = {32'd0, (pp_sel[1] ? a_q[63:32] : a_q[31:0])} *
			 {32'd0, (pp_sel[0] ? b_q[63:32] : b_q[31:0])};
		pp_sh  = {64'd0, pp} << {({1'b0, pp_sel[1]} + {1'b0, pp_sel[0]}), 5'd0};
		dtry   = {rem_q[63:0], a_q[95]};
		dge    = dtry >= {1'b0, b_q};
		stry   = {rem_q[49:0], a_q[95:94]};
		strial = {acc_q[49:0], 2'b01};
		sge    = stry >= strial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				unique case (req.op)
					OP_MUL:  cnt_q <= 7'd3;
					OP_DIV:  cnt_q <= req.len - 7'd1;
					OP_SQRT: cnt_q <= 7'd47;
					default: cnt_q <= 7'd0;
				endcase
			end else if (busy_q) begin
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			unique case (op_q)
				OP_MUL: acc_q <= acc_q + pp_sh;
				OP_DIV: begin
					rem_q <= dge ? (dtry - {1'b0, b_q}) : dtry;
					acc_q <= {acc_q[126:0], dge};
					a_q   <= {a_q[94:0], 1'b0};
				end
				OP_SQRT: begin
					rem_q <= {13'd0, (sge ? (stry - strial) : stry)};
					acc_q <= {acc_q[126:0], sge};
					a_q   <= {a_q[93:0], 2'b00};
				end
				default: ;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = acc_q;

endmodule

@@ hw/rtl/batched_weight_optimizer_top.sv @@
// When no step is due, an item passes through the index divide and the compare only.
// Gradient descent step: index divide, mean divide, rate multiply, clamp.
// Adam step: catch-up iterations (at most 16), plus the decay powers of a long
// catch-up; the shared unit sets the pace.
// One item at a time: input ready again once the result is registered, after any previous result is taken.
// Reset: asynchronous, clears configuration to defaults and optimizer state.
module batched_weight_optimizer_top
	import bwo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	bwo_item_if.sink    item,
	bwo_result_if.source result
);

	state_t state_q, state_d;
	logic   wait_q;
	logic   ovalid_q;

	logic               mode_q;
	logic [15:0]        bsz_q;
	logic [31:0]        lr_q;
	logic [31:0]        fr_q;
	logic signed [47:0] wmin_q;
	logic signed [47:0] wmax_q;
	logic [31:0]        b1_q;
	logic [31:0]        b2_q;

	logic signed [63:0] gsum_q;
	logic [32:0]        step_q;
	logic [31:0]        rate_q;
	logic               once_q;
	logic signed [47:0] m1_q;
	logic signed [47:0] m2_q;
	logic [32:0]        p1_q;
	logic [32:0]        p2_q;

	logic [31:0]        idx_q;
	logic signed [47:0] g_q;
	logic signed [63:0] w_q;
	logic               upd_q;
	logic [32:0]        cur_q;
	logic [32:0]        n_q;
	logic [4:0]         it_q;
	logic [4:0]         iters_q;
	logic signed [47:0] mean_q;
	logic [32:0]        sq_q;
	logic [31:0]        x_q;
	logic [63:0]        alpha_q;
	logic signed [63:0] s_q;
	logic [47:0]        gsq_q;
	logic [63:0]        den_q;
	logic [63:0]        t_q;
	logic [32:0]        qr_q;
	logic [31:0]        qb_q;
	logic [32:0]        qk_q;
	logic               sel_q;
	logic [47:0]        wout_q;
	logic               uout_q;

	unit_req_t req;
	unit_rsp_t ursp;
	logic      op_state;
	logic      unit_go;
	logic      unit_done;
	logic      accept;
	logic      leave_done;

	logic [15:0]        bs;
	logic [63:0]        gsum_mag;
	logic [47:0]        mean_mag;
	logic [47:0]        g_mag;
	logic [47:0]        m1_mag;
	logic [47:0]        m2_mag;
	logic [47:0]        ms_mag;
	logic [32:0]        om1;
	logic [32:0]        om2;
	logic [32:0]        omb1;
	logic [32:0]        omb2;
	logic [127:0]       prod;
	logic signed [64:0] gsum_add;
	logic signed [63:0] gsum_next;
	logic signed [63:0] g_ext;
	logic [63:0]        qdiv;
	logic signed [47:0] mean_new;
	logic [63:0]        term_mag;
	logic [49:0]        dstep;
	logic [47:0]        qm_mag;
	logic signed [47:0] qm_new;
	logic signed [63:0] wmax_x;
	logic signed [63:0] wmin_x;
	logic signed [63:0] w_hi;
	logic signed [63:0] w_lo;

	bwo_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_go),
		.req    (req),
		.rsp    (ursp)
	);

	assign unit_go    = op_state && !wait_q;
	assign unit_done  = ursp.done && wait_q;
	assign accept     = (state_q == ST_IDLE) && item.valid;
	assign leave_done = (state_q == ST_DONE) && (!ovalid_q || result.ready);
	assign prod       = ursp.res;

	always_comb begin
		bs        = (bsz_q == 16'd0) ? 16'd1 : bsz_q;
		gsum_mag  = gsum_q[63] ? (64'd0 - gsum_q) : gsum_q;
		mean_mag  = mag48(mean_q);
		g_mag     = mag48(g_q);
		m1_mag    = mag48(m1_q);
		m2_mag    = mag48(m2_q);
		ms_mag    = mag48(sel_q ? m2_q : m1_q);
		om1       = ONE32 - p1_q;
		om2       = ONE32 - p2_q;
		omb1      = ONE32 - {1'b0, b1_q};
		omb2      = ONE32 - {1'b0, b2_q};
		g_ext     = {{16{item.gradient[47]}}, item.gradient};
		gsum_add  = {gsum_q[63], gsum_q} + {g_ext[63], g_ext};
		if (gsum_add[64] != gsum_add[63])
			gsum_next = gsum_add[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		else
			gsum_next = gsum_add[63:0];
		qdiv = prod[63:0];
		if (gsum_q[63])
			mean_new = (qdiv > 64'h0000_8000_0000_0000) ? S48MIN : (48'd0 - qdiv[47:0]);
		else
			mean_new = (qdiv > 64'h0000_7FFF_FFFF_FFFF) ? S48MAX : qdiv[47:0];
		term_mag = prod[95:32];
		dstep    = (prod[95:0] > DELTA_CAP) ? DELTA_CAP[49:0] : prod[49:0];
		qm_mag   = prod[79:32];
		qm_new   = (sel_q ? m2_q[47] : m1_q[47]) ? (48'd0 - qm_mag) : qm_mag;
		wmax_x   = {{16{wmax_q[47]}}, wmax_q};
		wmin_x   = {{16{wmin_q[47]}}, wmin_q};
		w_hi     = (w_q > wmax_x) ? wmax_x : w_q;
		w_lo     = (w_hi < wmin_x) ? wmin_x : w_hi;
	end

	always_comb begin
		op_state = 1'b1;
		req      = '0;
		unique case (state_q)
			ST_IDX:   req = mk_req(OP_DIV, {idx_q, 64'd0}, {48'd0, bs}, 7'd32);
			ST_MEAN:  req = mk_req(OP_DIV, {gsum_mag, 32'd0}, {48'd0, bs}, 7'd64);
			ST_GD:    req = mk_req(OP_MUL, {64'd0, rate_q}, {16'd0, mean_mag}, 7'd0);
			ST_P1:    req = mk_req(OP_MUL, {63'd0, p1_q}, {32'd0, b1_q}, 7'd0);
			ST_P2:    req = mk_req(OP_MUL, {63'd0, p2_q}, {32'd0, b2_q}, 7'd0);
			ST_SQ1:   req = mk_req(OP_SQRT, {31'd0, om2, 32'd0}, 64'd0, 7'd0);
			ST_X:     req = mk_req(OP_MUL, {64'd0, rate_q}, {31'd0, sq_q}, 7'd0);
			ST_ALPHA: req = mk_req(OP_DIV, {x_q, 64'd0}, {31'd0, om1}, 7'd64);
			ST_M1A:   req = mk_req(OP_MUL, {64'd0, b1_q}, {16'd0, m1_mag}, 7'd0);
			ST_M1B:   req = mk_req(OP_MUL, {63'd0, omb1}, {16'd0, g_mag}, 7'd0);
			ST_GSQ:   req = mk_req(OP_MUL, {48'd0, g_mag}, {16'd0, g_mag}, 7'd0);
			ST_M2A:   req = mk_req(OP_MUL, {64'd0, b2_q}, {16'd0, m2_mag}, 7'd0);
			ST_M2B:   req = mk_req(OP_MUL, {63'd0, omb2}, {16'd0, gsq_q}, 7'd0);
			ST_SQ2:   req = mk_req(OP_SQRT, {16'd0, m2_q, 32'd0}, 64'd0, 7'd0);
			ST_T:     req = mk_req(OP_MUL, {32'd0, alpha_q}, {16'd0, m1_mag}, 7'd0);
			ST_DSTEP: req = mk_req(OP_DIV, {t_q, 32'd0}, den_q, 7'd96);
			ST_QMR:   req = mk_req(OP_MUL, {63'd0, qr_q}, {32'd0, qb_q}, 7'd0);
			ST_QMB:   req = mk_req(OP_MUL, {64'd0, qb_q}, {32'd0, qb_q}, 7'd0);
			ST_QPOW:  req = mk_req(OP_MUL, {63'd0, (sel_q ? p2_q : p1_q)}, {31'd0, qr_q}, 7'd0);
			ST_QMOM:  req = mk_req(OP_MUL, {63'd0, qr_q}, {16'd0, ms_mag}, 7'd0);
			default:  op_state = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (item.valid) state_d = ST_IDX;
			ST_IDX:   if (unit_done) state_d = ST_CHK;
			ST_CHK:   state_d = (step_q < cur_q) ? ST_MEAN : ST_DONE;
			ST_MEAN:  if (unit_done) state_d = mode_q ? ST_P1 : ST_GD;
			ST_GD:    if (unit_done) state_d = ST_CLAMP;
			ST_P1:    if (unit_done) state_d = ST_P2;
			ST_P2:    if (unit_done) state_d = ST_SQ1;
			ST_SQ1:   if (unit_done) state_d = ST_X;
			ST_X:     if (unit_done) state_d = ST_ALPHA;
			ST_ALPHA: if (unit_done) state_d = ST_M1A;
			ST_M1A:   if (unit_done) state_d = ST_M1B;
			ST_M1B:   if (unit_done) state_d = ST_GSQ;
			ST_GSQ:   if (unit_done) state_d = ST_M2A;
			ST_M2A:   if (unit_done) state_d = ST_M2B;
			ST_M2B:   if (unit_done) state_d = ST_SQ2;
			ST_SQ2:   if (unit_done) state_d = ST_T;
			ST_T:     if (unit_done) state_d = ST_DSTEP;
			ST_DSTEP: begin
				if (unit_done) begin
					if ((it_q + 5'd1) < iters_q)
						state_d = ST_P1;
					else if (n_q > CATCH_UP)
						state_d = ST_QINIT;
					else
						state_d = ST_CLAMP;
				end
			end
			ST_QINIT: state_d = ST_QTEST;
			ST_QTEST: begin
				if (qk_q == 33'd0)
					state_d = ST_QPOW;
				else
					state_d = qk_q[0] ? ST_QMR : ST_QMB;
			end
			ST_QMR:   if (unit_done) state_d = ST_QMB;
			ST_QMB:   if (unit_done) state_d = ST_QTEST;
			ST_QPOW:  if (unit_done) state_d = ST_QMOM;
			ST_QMOM:  if (unit_done) state_d = sel_q ? ST_CLAMP : ST_QINIT;
			ST_CLAMP: state_d = ST_DONE;
			ST_DONE:  if (!ovalid_q || result.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wait_q   <= 1'b0;
			ovalid_q <= 1'b0;
			mode_q   <= 1'b0;
			bsz_q    <= 16'd1;
			lr_q     <= RST_RATE;
			fr_q     <= RST_RATE;
			wmin_q   <= RST_WMIN;
			wmax_q   <= RST_WMAX;
			b1_q     <= RST_DECAY1;
			b2_q     <= RST_DECAY2;
			gsum_q   <= '0;
			step_q   <= 33'd1;
			rate_q   <= RST_RATE;
			once_q   <= 1'b0;
			m1_q     <= '0;
			m2_q     <= '0;
			p1_q     <= ONE32;
			p2_q     <= ONE32;
		end else begin
			state_q <= state_d;
			if (unit_go)
				wait_q <= 1'b1;
			else if (unit_done)
				wait_q <= 1'b0;
			if (leave_done)
				ovalid_q <= 1'b1;
			else if (result.ready)
				ovalid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_MODE:   mode_q <= cfg_data[0];
					REG_BATCH:  bsz_q  <= cfg_data[15:0];
					REG_LRATE:  lr_q   <= cfg_data[31:0];
					REG_FRATE:  fr_q   <= cfg_data[31:0];
					REG_WMIN:   wmin_q <= cfg_data;
					REG_WMAX:   wmax_q <= cfg_data;
					REG_DECAY1: b1_q   <= cfg_data[31:0];
					REG_DECAY2: b2_q   <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (accept) begin
				gsum_q <= gsum_next;
				if (!once_q)
					rate_q <= fr_q;
			end
			if (unit_done) begin
				unique case (state_q)
					ST_P1:   p1_q <= prod[64:32];
					ST_P2:   p2_q <= prod[64:32];
					ST_M1B:  m1_q <= sat48(s_q + (g_q[47] ? -$signed(term_mag)
									      : $signed(term_mag)));
					ST_M2B:  m2_q <= sat48(s_q + $signed(term_mag));
					ST_QPOW: begin
						if (sel_q)
							p2_q <= prod[64:32];
						else
							p1_q <= prod[64:32];
					end
					ST_QMOM: begin
						if (sel_q)
							m2_q <= qm_new;
						else
							m1_q <= qm_new;
					end
					default: ;
				endcase
			end
			if (state_q == ST_CLAMP) begin
				gsum_q <= '0;
				rate_q <= lr_q;
				once_q <= 1'b1;
				step_q <= cur_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= item.update_index;
			g_q   <= item.gradient;
			w_q   <= {{16{item.weight_in[47]}}, item.weight_in};
			upd_q <= 1'b0;
		end
		if (unit_done) begin
			unique case (state_q)
				ST_IDX:   cur_q <= {1'b0, prod[31:0]} + 33'd1;
				ST_MEAN: begin
					mean_q  <= mean_new;
					g_q     <= mean_new;
					n_q     <= cur_q - step_q;
					iters_q <= ((cur_q - step_q) < CATCH_UP) ? (cur_q[4:0] - step_q[4:0])
										: CATCH_UP[4:0];
					it_q    <= 5'd0;
					sel_q   <= 1'b0;
				end
				ST_GD:    w_q <= mean_q[47] ? (w_q + $signed({16'd0, prod[79:32]}))
							    : (w_q - $signed({16'd0, prod[79:32]}));
				ST_SQ1:   sq_q    <= prod[32:0];
				ST_X:     x_q     <= prod[63:32];
				ST_ALPHA: alpha_q <= prod[63:0];
				ST_M1A:   s_q <= m1_q[47] ? -$signed(term_mag) : $signed(term_mag);
				ST_GSQ:   gsq_q <= (prod[127:32] > GSQ_CAP) ? S48MAX : prod[79:32];
				ST_M2A:   s_q <= m2_q[47] ? -$signed(term_mag) : $signed(term_mag);
				ST_SQ2:   den_q <= prod[63:0] + EPSILON;
				ST_T:     t_q <= (prod[127:32] > T_CAP) ? T_CAP[63:0] : prod[95:32];
				ST_DSTEP: begin
					w_q  <= m1_q[47] ? (w_q + $signed({14'd0, dstep}))
							 : (w_q - $signed({14'd0, dstep}));
					it_q <= it_q + 5'd1;
					g_q  <= '0;
				end
				ST_QMR:   qr_q <= prod[64:32];
				ST_QMB: begin
					qb_q <= prod[63:32];
					qk_q <= {1'b0, qk_q[32:1]};
				end
				ST_QMOM:  sel_q <= 1'b1;
				default: ;
			endcase
		end
		if (state_q == ST_QINIT) begin
			qr_q <= ONE32;
			qb_q <= sel_q ? b2_q : b1_q;
			qk_q <= n_q - CATCH_UP;
		end
		if (state_q == ST_CLAMP) begin
			w_q   <= w_lo;
			upd_q <= 1'b1;
		end
		if (leave_done) begin
			wout_q <= w_q[47:0];
			uout_q <= upd_q;
		end
	end

	assign item.ready        = (state_q == ST_IDLE);
	assign result.valid      = ovalid_q;
	assign result.weight_out = wout_q;
	assign result.updated    = uout_q;

endmodule

@@ hw/rtl/bwo_checker.sv @@
`include "batched_weight_optimizer_top_assert.svh"

module bwo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [47:0] out_weight,
	input logic        out_updated
);

	`BWO_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`BWO_IMPL(a_result_after_work, clk, arst_n, $rose(out_valid), $past(!in_ready))
	`BWO_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`BWO_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_weight) && $stable(out_updated))

endmodule

bind batched_weight_optimizer_top bwo_checker u_bwo_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_weight  (result.weight_out),
	.out_updated (result.updated)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import bwo_pkg::*;

	typedef struct {
		logic [31:0]        idx;
		logic signed [47:0] grad;
		logic signed [47:0] wt;
		bit                 typed;
		logic signed [47:0] w_exp;
		bit                 u_exp;
	} stim_row_t;

	typedef struct {
		logic signed [47:0] w;
		bit                 u;
	} weight_res_t;

	localparam longint unsigned STEP_CAP = 64'd1 << 49;
	localparam longint unsigned PROD_CAP = 64'd1 << 62;
	localparam longint unsigned GSQ_MAX = (64'd1 << 47) - 1;
	localparam longint unsigned UNITY = 64'd1 << 32;
	localparam longint unsigned EPS_Q = 64'd429;
	localparam longint MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint MIN64 = 64'sh8000_0000_0000_0000;
	localparam logic signed [47:0] GMAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] GMIN = 48'sh8000_0000_0000;
	localparam logic signed [47:0] ONE_Q = 48'sh0001_0000_0000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;

	bwo_item_if   item();
	bwo_result_if result();

	batched_weight_optimizer_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (item),
		.result   (result)
	);

	// optimizer state mirror
	bit              opt_mode;
	logic [15:0]     opt_batch;
	longint unsigned opt_lrate, opt_frate, opt_decay1, opt_decay2;
	longint          opt_wmin, opt_wmax;
	longint          grad_sum;
	longint unsigned step_cnt, rate_cur, pow1, pow2;
	bit              once_done;
	longint          mom1, mom2;

	weight_res_t pending_weights[$];
	bit          failed;
	int          idle_pct;
	int          stall_pct;
	longint      idx_base;

	function automatic longint unsigned mul_shift(longint unsigned a, longint unsigned b,
						      int s, longint unsigned cap);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> s;
		if (p[127:64] != 0)
			return cap;
		return (p[63:0] > cap) ? cap : p[63:0];
	endfunction

	function automatic longint unsigned root_shift(longint unsigned x, int s);
		logic [127:0]    tgt;
		longint unsigned r, c;
		tgt = {64'd0, x} << s;
		r = 0;
		for (int b = 47; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= tgt)
				r = c;
		end
		return r;
	endfunction

	function automatic longint unsigned div_sat(longint unsigned t, int s, longint unsigned d,
						    longint unsigned cap);
		logic [127:0] q;
		if (d == 0)
			return (t != 0) ? cap : 0;
		q = ({64'd0, t} << s) / {64'd0, d};
		return (q > {64'd0, cap}) ? cap : q[63:0];
	endfunction

	function automatic longint unsigned abs64(longint x);
		return (x < 0) ? (64'd0 - longint'(x)) : x;
	endfunction

	function automatic longint clip48(longint x);
		if (x > longint'(GMAX))
			return longint'(GMAX);
		if (x < longint'(GMIN))
			return longint'(GMIN);
		return x;
	endfunction

	function automatic longint scale_q(longint unsigned f, longint x);
		longint r;
		r = longint'(mul_shift(f, abs64(x), 32, PROD_CAP));
		return (x < 0) ? -r : r;
	endfunction

	function automatic longint unsigned decay_pow(longint unsigned b, longint unsigned k);
		longint unsigned r;
		r = UNITY;
		while (k != 0) begin
			if (k[0])
				r = (r * b) >> 32;
			b = (b * b) >> 32;
			k = k >> 1;
		end
		return r;
	endfunction

	task automatic adam_iteration(input longint g, inout longint w);
		longint unsigned om1, om2, sq, x, alpha, gsq, den, t, d;
		pow1 = (pow1 * opt_decay1) >> 32;
		pow2 = (pow2 * opt_decay2) >> 32;
		om1 = UNITY - pow1;
		om2 = UNITY - pow2;
		sq = root_shift(om2, 32);
		x = (rate_cur * sq) >> 32;
		alpha = (x << 32) / om1;
		mom1 = clip48(scale_q(opt_decay1, mom1) + scale_q(UNITY - opt_decay1, g));
		gsq = mul_shift(abs64(g), abs64(g), 32, GSQ_MAX);
		mom2 = clip48(scale_q(opt_decay2, mom2) + scale_q(UNITY - opt_decay2, longint'(gsq)));
		den = root_shift(longint'(mom2), 32) + EPS_Q;
		t = mul_shift(alpha, abs64(mom1), 32, PROD_CAP);
		d = div_sat(t, 32, den, STEP_CAP);
		if (mom1 < 0)
			w = w + longint'(d);
		else
			w = w - longint'(d);
	endtask

	task automatic predict_weight(input logic [31:0] idx, input logic signed [47:0] g_in,
				      input logic signed [47:0] w_in, output weight_res_t res);
		longint          g, w, mean, d;
		longint unsigned bs, cur, n, iters, f1, f2;
		g = g_in;
		w = w_in;
		bs = (opt_batch != 0) ? opt_batch : 1;
		res.u = 0;
		if (!once_done)
			rate_cur = opt_frate;
		if (g > 0 && grad_sum > MAX64 - g)
			grad_sum = MAX64;
		else if (g < 0 && grad_sum < MIN64 - g)
			grad_sum = MIN64;
		else
			grad_sum = grad_sum + g;
		cur = 1 + longint'(idx) / bs;
		if (step_cnt < cur) begin
			mean = clip48(grad_sum / longint'(bs));
			if (!opt_mode) begin
				d = longint'(mul_shift(rate_cur, abs64(mean), 32, STEP_CAP));
				w = (mean < 0) ? w + d : w - d;
			end else begin
				n = cur - step_cnt;
				iters = (n < 16) ? n : 16;
				for (longint unsigned i = 0; i < iters; i++)
					adam_iteration((i == 0) ? mean : 0, w);
				if (n > iters) begin
					f1 = decay_pow(opt_decay1, n - iters);
					f2 = decay_pow(opt_decay2, n - iters);
					pow1 = (pow1 * f1) >> 32;
					pow2 = (pow2 * f2) >> 32;
					mom1 = scale_q(f1, mom1);
					mom2 = scale_q(f2, mom2);
				end
			end
			grad_sum = 0;
			if (w > opt_wmax)
				w = opt_wmax;
			if (w < opt_wmin)
				w = opt_wmin;
			rate_cur = opt_lrate;
			once_done = 1;
			step_cnt = cur;
			res.u = 1;
		end
		res.w = w[47:0];
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		result.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		weight_res_t e;
		if (result.valid && result.ready) begin
			if (pending_weights.size() == 0) begin
				$display("%0t: unexpected beat weight %h updated %b", $time,
					 result.weight_out, result.updated);
				failed = 1;
			end else begin
				e = pending_weights.pop_front();
				if (result.weight_out !== e.w) begin
					$display("%0t: weight expected %h actual %h", $time, e.w,
						 result.weight_out);
					failed = 1;
				end
				if (result.updated !== e.u) begin
					$display("%0t: updated expected %b actual %b", $time, e.u,
						 result.updated);
					failed = 1;
				end
			end
		end
	end

	task automatic reg_write(input cfg_reg_t r, input logic [47:0] v);
		cfg_we <= 1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		case (r)
			REG_MODE:   opt_mode = v[0];
			REG_BATCH:  opt_batch = v[15:0];
			REG_LRATE:  opt_lrate = v[31:0];
			REG_FRATE:  opt_frate = v[31:0];
			REG_WMIN:   opt_wmin = longint'(signed'(v));
			REG_WMAX:   opt_wmax = longint'(signed'(v));
			REG_DECAY1: opt_decay1 = v[31:0];
			REG_DECAY2: opt_decay2 = v[31:0];
			default: ;
		endcase
	endtask

	task automatic configure(input bit mode, input logic [15:0] bs, input logic [31:0] lr,
				 input logic [31:0] fr, input logic [47:0] wmin, input logic [47:0] wmax,
				 input logic [31:0] d1, input logic [31:0] d2);
		item.valid <= 0;
		while (pending_weights.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		reg_write(REG_MODE, {47'd0, mode});
		reg_write(REG_BATCH, {32'd0, bs});
		reg_write(REG_LRATE, {16'd0, lr});
		reg_write(REG_FRATE, {16'd0, fr});
		reg_write(REG_WMIN, wmin);
		reg_write(REG_WMAX, wmax);
		reg_write(REG_DECAY1, {16'd0, d1});
		reg_write(REG_DECAY2, {16'd0, d2});
		cfg_we <= 0;
		idx_base = step_cnt * ((opt_batch != 0) ? opt_batch : 1);
	endtask

	task automatic send_item(input logic [31:0] idx, input logic signed [47:0] g,
				 input logic signed [47:0] w, output weight_res_t res);
		while ($urandom_range(99) < idle_pct) begin
			item.valid <= 0;
			@(posedge clk);
		end
		item.valid <= 1;
		item.update_index <= idx;
		item.gradient <= g;
		item.weight_in <= w;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		predict_weight(idx, g, w, res);
		pending_weights.push_back(res);
	endtask

	function automatic logic signed [47:0] pick_value(int span_bits);
		logic [47:0] r;
		if ($urandom_range(3) == 0) begin
			r = 48'({$urandom, $urandom});
			return signed'(r);
		end
		r = 48'({$urandom, $urandom}) & ((48'd1 << span_bits) - 48'd1);
		return signed'(r) - (48'sd1 <<< (span_bits - 1));
	endfunction

	initial begin
		stim_row_t   dir_tab[10];
		weight_res_t res;
		logic [31:0] lr, d1, d2;
		logic [47:0] wmin, wmax;
		logic [15:0] bsel[8];
		longint      idx;
		int          r;

		failed = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n <= 0;
		cfg_we <= 0;
		cfg_index <= REG_MODE;
		cfg_data <= 0;
		item.valid <= 0;
		item.update_index <= 0;
		item.gradient <= 0;
		item.weight_in <= 0;

		opt_mode = 0;
		opt_batch = 1;
		opt_lrate = RST_RATE;
		opt_frate = RST_RATE;
		opt_wmin = longint'(signed'(RST_WMIN));
		opt_wmax = longint'(signed'(RST_WMAX));
		opt_decay1 = RST_DECAY1;
		opt_decay2 = RST_DECAY2;
		grad_sum = 0;
		step_cnt = 1;
		rate_cur = RST_RATE;
		once_done = 0;
		mom1 = 0;
		mom2 = 0;
		pow1 = UNITY;
		pow2 = UNITY;
		idx_base = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		dir_tab = '{
			'{32'd0, 48'sd0, 48'sd0, 1, 48'sd0, 0},
			'{32'd0, GMAX, GMAX, 1, GMAX, 0},
			'{32'd0, GMIN, GMIN, 1, GMIN, 0},
			'{32'd1, ONE_Q, 2 * ONE_Q, 0, 48'sd0, 0},
			'{32'd1, 48'sd0, 48'sd5, 1, 48'sd5, 0},
			'{32'd0, 48'sd0, -48'sd5, 1, -48'sd5, 0},
			'{32'd3, GMAX, 48'sd0, 0, 48'sd0, 0},
			'{32'd4, GMIN, GMAX, 0, 48'sd0, 0},
			'{32'd393210, -ONE_Q, 48'sd0, 0, 48'sd0, 0},
			'{32'hFFFF_FFFF, GMIN, GMIN, 0, 48'sd0, 0}
		};
		for (int i = 0; i < 10; i++) begin
			if (i == 8)
				configure(1, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, GMIN, GMAX, 32'd0,
					  32'hFFFF_FFFF);
			send_item(dir_tab[i].idx, dir_tab[i].grad, dir_tab[i].wt, res);
			if (dir_tab[i].typed && (res.w !== dir_tab[i].w_exp || res.u !== dir_tab[i].u_exp)) begin
				$display("%0t: table row %0d expected %h/%b actual %h/%b", $time, i,
					 dir_tab[i].w_exp, dir_tab[i].u_exp, res.w, res.u);
				failed = 1;
			end
		end

		bsel = '{16'd1, 16'd3, 16'd1, 16'd7, 16'd2, 16'd300, 16'd1, 16'd4};
		for (int p = 0; p < 8; p++) begin
			lr = (p == 2) ? 32'hFFFF_FFFF : (p == 4) ? 32'd0 : $urandom_range(0, 32'h0100_0000);
			d1 = (p == 3) ? 32'd0 : (p == 5) ? 32'hFFFF_FFFF : $urandom_range(32'hC000_0000,
											32'hF000_0000);
			d2 = (p == 3) ? 32'd0 : (p == 5) ? 32'hFFFF_FFFF : $urandom_range(32'hF000_0000,
											32'hFFFF_0000);
			wmin = (p == 6) ? 48'h0005_0000_0000 : (p == 7) ? GMIN : RST_WMIN;
			wmax = (p == 6) ? 48'hFFFB_0000_0000 : (p == 7) ? GMAX : RST_WMAX;
			configure(p[0], bsel[p], lr, $urandom, wmin, wmax, d1, d2);
			case (p % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 78; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 78; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			for (int k = 0; k < 50; k++) begin
				r = $urandom_range(99);
				if (r < 10) begin
					idx = idx_base - $urandom_range(0, 2 * bsel[p]);
					if (idx < 0)
						idx = 0;
				end else begin
					if (r < 15)
						idx_base += longint'(bsel[p]) * $urandom_range(16, 40);
					else if (r < 17)
						idx_base += longint'(bsel[p]) * $urandom_range(1000, 5000);
					else
						idx_base += $urandom_range(0, 2 * bsel[p]);
					idx = idx_base;
				end
				send_item(idx[31:0], pick_value(35), pick_value(38), res);
			end
		end

		item.valid <= 0;
		stall_pct = 32;
		while (pending_weights.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (!failed)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
